### rtl/session_lifecycle_fsm_core_defines.svh
// Assertion macros for the session lifecycle core.
// Used by session_lifecycle_fsm_core; expects clk and rst_n in scope.
`ifndef SESSION_LIFECYCLE_FSM_CORE_DEFINES_SVH
`define SESSION_LIFECYCLE_FSM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SLF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slf: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slf: next-cycle check failed");
`else
`define SLF_ASSERT_NOW(label, ante, cons)
`define SLF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/slf_pkg.sv
// Shared types and codes for the session lifecycle core.
// No dependencies.
`timescale 1ns / 1ps

package slf_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [STATE_W-1:0] {
    ST_DISC         = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_CONNECTED    = 3'd2,
    ST_INITIALIZING = 3'd3,
    ST_READY        = 3'd4,
    ST_DRAINING     = 3'd5,
    ST_ERROR        = 3'd6,
    ST_CLOSED       = 3'd7
  } state_t;

  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SOFT  = 2'd2;

  localparam logic [EVENT_W-1:0] EV_CONNREQ   = 4'd0;
  localparam logic [EVENT_W-1:0] EV_NETUP     = 4'd1;
  localparam logic [EVENT_W-1:0] EV_NETDOWN   = 4'd2;
  localparam logic [EVENT_W-1:0] EV_INITREQ   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_INITSENT  = 4'd4;
  localparam logic [EVENT_W-1:0] EV_INITRECV  = 4'd5;
  localparam logic [EVENT_W-1:0] EV_INITED    = 4'd6;
  localparam logic [EVENT_W-1:0] EV_SHUTDOWN  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_DRAINED   = 4'd8;
  localparam logic [EVENT_W-1:0] EV_PROTERR   = 4'd9;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT   = 4'd10;
  localparam logic [EVENT_W-1:0] EV_RECONNREQ = 4'd11;
  localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RECONNECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECONNECTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_LIMIT    = 3'd4;

  localparam logic [COUNT_W-1:0] MAX_RECONNECTS_RST = 8'd3;
  localparam logic [TICK_W-1:0]  LIMIT_RST          = 16'd1000;
  localparam logic [TICK_W-1:0]  TICK_MAX           = 16'hFFFF;

  typedef struct packed {
    logic               auto_reconnect_enable;
    logic [COUNT_W-1:0] max_reconnects;
    logic [TICK_W-1:0]  connect_limit_ticks;
    logic [TICK_W-1:0]  init_limit_ticks;
    logic [TICK_W-1:0]  drain_limit_ticks;
  } cfg_t;

  typedef struct packed {
    logic               changed;
    state_t             prior_state;
    state_t             current_state;
    logic [EVENT_W-1:0] trigger_code;
    logic               timed_out;
    logic [COUNT_W-1:0] attempts_used;
  } res_t;

  typedef struct packed {
    state_t             fsm_state;
    logic               timer_armed;
    logic [COUNT_W-1:0] reconnect_count;
  } status_t;

endpackage

### rtl/slf_in_if.sv
// Input item channel: valid/ready plus func and event code.
// Depends on slf_pkg.
`timescale 1ns / 1ps

interface slf_in_if
  import slf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [EVENT_W-1:0] event_code;

  modport source (output valid, output func, output event_code, input ready);
  modport sink   (input valid, input func, input event_code, output ready);
endinterface

### rtl/slf_out_if.sv
// Result item channel: valid/ready plus transition report fields.
// Depends on slf_pkg.
`timescale 1ns / 1ps

interface slf_out_if
  import slf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               changed;
  logic [STATE_W-1:0] prior_state;
  logic [STATE_W-1:0] current_state;
  logic [EVENT_W-1:0] trigger_code;
  logic               timed_out;
  logic [COUNT_W-1:0] attempts_used;

  modport source (output valid, output changed, output prior_state, output current_state,
                  output trigger_code, output timed_out, output attempts_used,
                  input ready);
  modport sink   (input valid, input changed, input prior_state, input current_state,
                  input trigger_code, input timed_out, input attempts_used,
                  output ready);
endinterface

### rtl/slf_cfg.sv
// Configuration register file for the session lifecycle core.
// Depends on slf_pkg.
`timescale 1ns / 1ps

module slf_cfg
  import slf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_AUTO_RECONNECT: cfg_nxt.auto_reconnect_enable = cfg_wdata[0];
        CFG_MAX_RECONNECTS: cfg_nxt.max_reconnects        = cfg_wdata[COUNT_W-1:0];
        CFG_CONNECT_LIMIT:  cfg_nxt.connect_limit_ticks   = cfg_wdata[TICK_W-1:0];
        CFG_INIT_LIMIT:     cfg_nxt.init_limit_ticks      = cfg_wdata[TICK_W-1:0];
        CFG_DRAIN_LIMIT:    cfg_nxt.drain_limit_ticks     = cfg_wdata[TICK_W-1:0];
        default:            cfg_nxt = cfg_r;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_reconnect_enable <= 1'b0;
      cfg_r.max_reconnects        <= MAX_RECONNECTS_RST;
      cfg_r.connect_limit_ticks   <= LIMIT_RST;
      cfg_r.init_limit_ticks      <= LIMIT_RST;
      cfg_r.drain_limit_ticks     <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/slf_fsm.sv
// Lifecycle state machine, reconnect counter and per-state tick timer.
// Evaluates one registered item per cycle while commit is high. Depends on slf_pkg.
`timescale 1ns / 1ps

module slf_fsm
  import slf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               commit,      // item is consumed this cycle
  input  logic [FUNC_W-1:0]  item_func,
  input  logic [EVENT_W-1:0] item_event,
  output res_t               res,
  output status_t            status
);

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic                armed_r, armed_nxt;

  logic [TICK_W-1:0]   elapsed_inc;
  logic [TICK_W-1:0]   limit;
  logic                is_event, is_tick, is_soft;
  logic                expire, apply;
  logic [EVENT_W-1:0]  ev;
  state_t              ns;
  logic                retry_ok;
  logic                cnt_inc, cnt_clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_DISC;
      count_r   <= '0;
      elapsed_r <= '0;
      armed_r   <= 1'b0;
    end else if (commit) begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      armed_r   <= armed_nxt;
    end
  end

  always_comb begin
    is_event = (item_func == FUNC_EVENT);
    is_tick  = (item_func == FUNC_TICK);
    is_soft  = (item_func == FUNC_SOFT);

    elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;
    case (state_r)
      ST_CONNECTING:   limit = cfg.connect_limit_ticks;
      ST_INITIALIZING: limit = cfg.init_limit_ticks;
      ST_DRAINING:     limit = cfg.drain_limit_ticks;
      default:         limit = TICK_MAX;
    endcase
    expire = is_tick && armed_r && (elapsed_inc >= limit);
    apply  = is_event || expire;
    ev     = is_event ? item_event : EV_TIMEOUT;

    retry_ok = (count_r < cfg.max_reconnects);
    cnt_inc  = 1'b0;
    cnt_clr  = 1'b0;
    ns       = state_r;
    case (state_r)
      ST_DISC: begin
        if (ev == EV_CONNREQ)    ns = ST_CONNECTING;
        else if (ev == EV_NETUP) ns = ST_CONNECTED;
      end
      ST_CONNECTING: begin
        if (ev == EV_NETUP)                             ns = ST_CONNECTED;
        else if (ev == EV_NETDOWN || ev == EV_TIMEOUT)  ns = ST_DISC;
        else if (ev == EV_PROTERR)                      ns = ST_ERROR;
      end
      ST_CONNECTED: begin
        if (ev inside {EV_INITREQ, EV_INITSENT}) ns = ST_INITIALIZING;
        else if (ev == EV_NETDOWN)               ns = ST_DISC;
        else if (ev == EV_PROTERR)               ns = ST_ERROR;
      end
      ST_INITIALIZING: begin
        if (ev inside {EV_INITED, EV_INITRECV})       ns = ST_READY;
        else if (ev inside {EV_TIMEOUT, EV_PROTERR})  ns = ST_ERROR;
        else if (ev == EV_NETDOWN)                    ns = ST_DISC;
      end
      ST_READY: begin
        if (ev == EV_SHUTDOWN) begin
          ns = ST_DRAINING;
        end else if (ev == EV_NETDOWN) begin
          if (cfg.auto_reconnect_enable && retry_ok) begin
            ns      = ST_CONNECTING;
            cnt_inc = 1'b1;
          end else begin
            ns = ST_DISC;
          end
        end else if (ev == EV_PROTERR) begin
          ns = ST_ERROR;
        end
      end
      ST_DRAINING: begin
        if (ev inside {EV_DRAINED, EV_TIMEOUT, EV_NETDOWN}) ns = ST_CLOSED;
      end
      ST_ERROR: begin
        if (ev == EV_RECONNREQ) begin
          if (retry_ok) begin
            ns      = ST_CONNECTING;
            cnt_inc = 1'b1;
          end
        end else if (ev == EV_SHUTDOWN) begin
          ns = ST_CLOSED;
        end
      end
      ST_CLOSED: begin
        if (ev == EV_CONNREQ) begin
          ns      = ST_CONNECTING;
          cnt_clr = 1'b1;
        end
      end
      default: ns = state_r;
    endcase

    state_nxt   = state_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    armed_nxt   = armed_r;

    if (is_tick && armed_r) begin
      elapsed_nxt = elapsed_inc;
      if (expire) armed_nxt = 1'b0;
    end

    if (apply && (ns != state_r)) begin
      state_nxt = ns;
      armed_nxt = (ns inside {ST_CONNECTING, ST_INITIALIZING, ST_DRAINING});
      if (armed_nxt) elapsed_nxt = '0;
      if (cnt_clr)      count_nxt = '0;
      else if (cnt_inc) count_nxt = count_r + 1'b1;
    end

    if (is_soft) begin
      state_nxt   = ST_DISC;
      count_nxt   = '0;
      elapsed_nxt = '0;
      armed_nxt   = 1'b0;
    end

    res.changed       = (state_nxt != state_r);
    res.prior_state   = state_r;
    res.current_state = state_nxt;
    res.trigger_code  = is_event ? item_event : (expire ? EV_TIMEOUT : EV_NONE);
    res.timed_out     = expire;
    res.attempts_used = count_nxt;
  end

  assign status.fsm_state       = state_r;
  assign status.timer_armed     = armed_r;
  assign status.reconnect_count = count_r;

endmodule

### rtl/session_lifecycle_fsm_core.sv
// Session lifecycle core: top level with input and result registers.
// Depends on slf_pkg, slf_in_if, slf_out_if, slf_cfg, slf_fsm and the defines header.
`timescale 1ns / 1ps
`include "session_lifecycle_fsm_core_defines.svh"

// Eight-state connection lifecycle machine (disconnected, connecting, connected,
// initializing, ready, draining, error, closed). Each input item is an event, a
// time tick or a soft reset, and yields exactly one result item reporting the
// prior and new state, the trigger, whether the state timer expired, and the
// reconnect attempt count. Throughput is one item per clock while the result
// register can advance. The item sits in the input register, and the result
// register is loaded together with the state update when the item fires. The
// state, count and timer registers update in the same cycle the result is
// captured, so the next item sees them directly. A held result does not block
// the input register from filling; input backpressure appears only when both
// registers hold items.
// Configuration writes take effect on the next clock and should be issued only
// while no item is in flight.
module session_lifecycle_fsm_core
  import slf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  slf_in_if.sink                in_ch,
  slf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  res_t    res;
  status_t status;

  // Input register
  logic               in_valid_r, in_valid_nxt;
  logic [FUNC_W-1:0]  in_func_r;
  logic [EVENT_W-1:0] in_event_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  logic in_accept;
  logic advance;   // result register can take a new item
  logic fire;      // registered item is evaluated and committed

  // Check helpers
  logic timed_state;  // state that runs the tick timer
  logic res_moved;    // held result reports differing states
  logic expiry_ok;    // held result reports a timeout transition

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept)  in_valid_nxt = 1'b1;
    else if (fire)  in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (fire)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_func_r  <= in_ch.func;
      in_event_r <= in_ch.event_code;
    end
    if (fire) out_res_r <= res;
  end

  slf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slf_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .commit     (fire),
    .item_func  (in_func_r),
    .item_event (in_event_r),
    .res        (res),
    .status     (status)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.changed       = out_res_r.changed;
  assign out_ch.prior_state   = out_res_r.prior_state;
  assign out_ch.current_state = out_res_r.current_state;
  assign out_ch.trigger_code  = out_res_r.trigger_code;
  assign out_ch.timed_out     = out_res_r.timed_out;
  assign out_ch.attempts_used = out_res_r.attempts_used;

  assign timed_state = (status.fsm_state == ST_CONNECTING) ||
                       (status.fsm_state == ST_INITIALIZING) ||
                       (status.fsm_state == ST_DRAINING);
  assign res_moved   = (out_res_r.prior_state != out_res_r.current_state);
  assign expiry_ok   = (out_res_r.trigger_code == EV_TIMEOUT) && out_res_r.changed;

  // Timer only runs in the three timed states.
  `SLF_ASSERT_NOW(a_armed_state, status.timer_armed, timed_state)
  // changed flag agrees with the reported states.
  `SLF_ASSERT_NOW(a_changed_match, out_valid_r, out_res_r.changed == res_moved)
  // An expiry always reports the timeout trigger and a transition.
  `SLF_ASSERT_NOW(a_expiry_report, out_valid_r && out_res_r.timed_out, expiry_ok)
  // A committed item's new state is the state seen by the next item.
  `SLF_ASSERT_NEXT(a_state_follows, fire, status.fsm_state == out_res_r.current_state)

endmodule

### bench/session_lifecycle_fsm_core_tb.sv
// Testbench for session_lifecycle_fsm_core: drives events, ticks and soft resets,
// predicts each transition report and checks every result item field by field.
// Depends on slf_pkg, slf_in_if, slf_out_if and the core itself.
`timescale 1ns / 1ps

// Tracks the expected lifecycle state and the reports that are still owed.
class lifecycle_scoreboard;
  // register copy
  logic                        auto_en;
  logic [slf_pkg::COUNT_W-1:0] max_rc;
  logic [slf_pkg::TICK_W-1:0]  lim_connect;
  logic [slf_pkg::TICK_W-1:0]  lim_init;
  logic [slf_pkg::TICK_W-1:0]  lim_drain;
  // machine copy
  slf_pkg::state_t             fsm;
  logic [slf_pkg::COUNT_W-1:0] attempts;
  logic [slf_pkg::TICK_W-1:0]  ticks;
  logic                        armed;
  slf_pkg::res_t               pending_reports[$];
  int unsigned                 errors;
  int unsigned                 reports_checked;
  int unsigned                 expiries;
  int unsigned                 transitions;

  function new();
    auto_en     = 1'b0;
    max_rc      = slf_pkg::MAX_RECONNECTS_RST;
    lim_connect = slf_pkg::LIMIT_RST;
    lim_init    = slf_pkg::LIMIT_RST;
    lim_drain   = slf_pkg::LIMIT_RST;
    fsm         = slf_pkg::ST_DISC;
    attempts    = '0;
    ticks       = '0;
    armed       = 1'b0;
    errors      = 0;
    reports_checked = 0;
    expiries    = 0;
    transitions = 0;
  endfunction

  function void set_reg(logic [slf_pkg::CFG_IDX_W-1:0] idx,
                        logic [slf_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      slf_pkg::CFG_AUTO_RECONNECT: auto_en     = val[0];
      slf_pkg::CFG_MAX_RECONNECTS: max_rc      = val[slf_pkg::COUNT_W-1:0];
      slf_pkg::CFG_CONNECT_LIMIT:  lim_connect = val;
      slf_pkg::CFG_INIT_LIMIT:     lim_init    = val;
      slf_pkg::CFG_DRAIN_LIMIT:    lim_drain   = val;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return pending_reports.size();
  endfunction

  // Transition table; reconnect paths also bump or clear the attempt count.
  function slf_pkg::state_t next_fsm(slf_pkg::state_t s, logic [slf_pkg::EVENT_W-1:0] ev);
    case (s)
      slf_pkg::ST_DISC: begin
        if (ev == slf_pkg::EV_CONNREQ) return slf_pkg::ST_CONNECTING;
        if (ev == slf_pkg::EV_NETUP) return slf_pkg::ST_CONNECTED;
      end
      slf_pkg::ST_CONNECTING: begin
        if (ev == slf_pkg::EV_NETUP) return slf_pkg::ST_CONNECTED;
        if (ev == slf_pkg::EV_NETDOWN || ev == slf_pkg::EV_TIMEOUT) return slf_pkg::ST_DISC;
        if (ev == slf_pkg::EV_PROTERR) return slf_pkg::ST_ERROR;
      end
      slf_pkg::ST_CONNECTED: begin
        if (ev == slf_pkg::EV_INITREQ || ev == slf_pkg::EV_INITSENT)
          return slf_pkg::ST_INITIALIZING;
        if (ev == slf_pkg::EV_NETDOWN) return slf_pkg::ST_DISC;
        if (ev == slf_pkg::EV_PROTERR) return slf_pkg::ST_ERROR;
      end
      slf_pkg::ST_INITIALIZING: begin
        if (ev == slf_pkg::EV_INITED || ev == slf_pkg::EV_INITRECV) return slf_pkg::ST_READY;
        if (ev == slf_pkg::EV_TIMEOUT || ev == slf_pkg::EV_PROTERR) return slf_pkg::ST_ERROR;
        if (ev == slf_pkg::EV_NETDOWN) return slf_pkg::ST_DISC;
      end
      slf_pkg::ST_READY: begin
        if (ev == slf_pkg::EV_SHUTDOWN) return slf_pkg::ST_DRAINING;
        if (ev == slf_pkg::EV_NETDOWN) begin
          if (auto_en && attempts < max_rc) begin
            attempts = attempts + 1'b1;
            return slf_pkg::ST_CONNECTING;
          end
          return slf_pkg::ST_DISC;
        end
        if (ev == slf_pkg::EV_PROTERR) return slf_pkg::ST_ERROR;
      end
      slf_pkg::ST_DRAINING: begin
        if (ev == slf_pkg::EV_DRAINED || ev == slf_pkg::EV_TIMEOUT ||
            ev == slf_pkg::EV_NETDOWN) return slf_pkg::ST_CLOSED;
      end
      slf_pkg::ST_ERROR: begin
        if (ev == slf_pkg::EV_RECONNREQ && attempts < max_rc) begin
          attempts = attempts + 1'b1;
          return slf_pkg::ST_CONNECTING;
        end
        if (ev == slf_pkg::EV_SHUTDOWN) return slf_pkg::ST_CLOSED;
      end
      default: begin
        if (ev == slf_pkg::EV_CONNREQ) begin
          attempts = '0;
          return slf_pkg::ST_CONNECTING;
        end
      end
    endcase
    return s;
  endfunction

  // Applies an event; any real move disarms, timed states re-arm from zero.
  function logic take_event(logic [slf_pkg::EVENT_W-1:0] ev);
    slf_pkg::state_t ns;
    ns = next_fsm(fsm, ev);
    if (ns == fsm) return 1'b0;
    fsm   = ns;
    armed = 1'b0;
    if (ns == slf_pkg::ST_CONNECTING || ns == slf_pkg::ST_INITIALIZING ||
        ns == slf_pkg::ST_DRAINING) begin
      ticks = '0;
      armed = 1'b1;
    end
    transitions++;
    return 1'b1;
  endfunction

  function logic [slf_pkg::TICK_W-1:0] limit_now();
    case (fsm)
      slf_pkg::ST_CONNECTING:   return lim_connect;
      slf_pkg::ST_INITIALIZING: return lim_init;
      slf_pkg::ST_DRAINING:     return lim_drain;
      default:                  return slf_pkg::TICK_MAX;
    endcase
  endfunction

  // Called on every accepted input item; queues the report it must produce.
  function void note_item(logic [slf_pkg::FUNC_W-1:0] f, logic [slf_pkg::EVENT_W-1:0] ev);
    slf_pkg::res_t r;
    r = '0;
    r.prior_state = fsm;
    case (f)
      slf_pkg::FUNC_EVENT: begin
        r.trigger_code = ev;
        r.changed      = take_event(ev);
      end
      slf_pkg::FUNC_TICK: begin
        if (armed) begin
          if (ticks != slf_pkg::TICK_MAX) ticks = ticks + 1'b1;
          if (ticks >= limit_now()) begin
            r.timed_out    = 1'b1;
            armed          = 1'b0;
            r.trigger_code = slf_pkg::EV_TIMEOUT;
            r.changed      = take_event(slf_pkg::EV_TIMEOUT);
            expiries++;
          end
        end
      end
      slf_pkg::FUNC_SOFT: begin
        r.changed = (fsm != slf_pkg::ST_DISC);
        fsm      = slf_pkg::ST_DISC;
        attempts = '0;
        ticks    = '0;
        armed    = 1'b0;
      end
      default: ;
    endcase
    r.current_state = fsm;
    r.attempts_used = attempts;
    pending_reports.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endfunction

  function void check_report(slf_pkg::res_t got);
    slf_pkg::res_t want;
    if (pending_reports.size() == 0) begin
      $error("result item arrived with nothing outstanding");
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    compare_field("changed", 16'(want.changed), 16'(got.changed));
    compare_field("prior_state", 16'(want.prior_state), 16'(got.prior_state));
    compare_field("current_state", 16'(want.current_state), 16'(got.current_state));
    compare_field("trigger_code", 16'(want.trigger_code), 16'(got.trigger_code));
    compare_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
    compare_field("attempts_used", 16'(want.attempts_used), 16'(got.attempts_used));
  endfunction
endclass

module session_lifecycle_fsm_core_tb;
  import slf_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned DRAIN_SLACK    = 4;    // input and result registers plus margin
  localparam int unsigned RX_HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned PHASES         = 6;

  // Codes the block must ignore or treat as no-ops.
  localparam logic [FUNC_W-1:0]  FUNC_UNUSED    = 2'd3;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN_LO  = 4'd12;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN_HI  = 4'd15;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slf_in_if  in_ch();
  slf_out_if out_ch();

  lifecycle_scoreboard sb = new();

  // Shared knobs between the stimulus thread and the result sink.
  bit          rx_hold_req = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          tx_steady   = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned settings    = 0;
  int unsigned cycles      = 0;

  always #10 clk = ~clk;

  session_lifecycle_fsm_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor: sample pre-edge values, so ordering within the step is moot.
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.changed       = out_ch.changed;
      got.prior_state   = state_t'(out_ch.prior_state);
      got.current_state = state_t'(out_ch.current_state);
      got.trigger_code  = out_ch.trigger_code;
      got.timed_out     = out_ch.timed_out;
      got.attempts_used = out_ch.attempts_used;
      sb.check_report(got);
    end
  end

  // Result sink. Mostly short stalls, a few long ones; a hold request drops
  // ready for RX_HOLD_CYCLES, counted here, so the core backs up into its input.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_count;
    stall_left = 0;
    hold_count = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count == RX_HOLD_CYCLES) begin
          hold_count  = 0;
          rx_hold_req = 1'b0;
        end
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the core takes it. valid stays high on
  // return so back-to-back items need no extra edge.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [EVENT_W-1:0] e);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.event_code <= e;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(f, e);
    items_sent++;
  endtask

  // Idle for a random stretch: mostly none, some short, a few long.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 65) n = 0;
    else if (roll < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender pause: stop offering until every report has come back, then let
  // the pipeline settle before anything touches the registers.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // One write per edge; the caller drops the enable after the last one.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] auto_v,
                              input logic [CFG_DATA_W-1:0] max_v,
                              input logic [CFG_DATA_W-1:0] conn_v,
                              input logic [CFG_DATA_W-1:0] init_v,
                              input logic [CFG_DATA_W-1:0] drain_v);
    set_register(CFG_AUTO_RECONNECT, auto_v);
    set_register(CFG_MAX_RECONNECTS, max_v);
    set_register(CFG_CONNECT_LIMIT, conn_v);
    set_register(CFG_INIT_LIMIT, init_v);
    set_register(CFG_DRAIN_LIMIT, drain_v);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Pick an event that tends to move the session forward from state s.
  function automatic logic [EVENT_W-1:0] forward_event(state_t s);
    logic [EVENT_W-1:0] opt[4];
    case (s)
      ST_DISC:         opt = '{EV_CONNREQ, EV_CONNREQ, EV_CONNREQ, EV_NETUP};
      ST_CONNECTING:   opt = '{EV_NETUP, EV_NETUP, EV_NETDOWN, EV_PROTERR};
      ST_CONNECTED:    opt = '{EV_INITREQ, EV_INITSENT, EV_NETDOWN, EV_PROTERR};
      ST_INITIALIZING: opt = '{EV_INITED, EV_INITRECV, EV_INITED, EV_PROTERR};
      ST_READY:        opt = '{EV_SHUTDOWN, EV_NETDOWN, EV_NETDOWN, EV_PROTERR};
      ST_DRAINING:     opt = '{EV_DRAINED, EV_NETDOWN, EV_TIMEOUT, EV_DRAINED};
      ST_ERROR:        opt = '{EV_RECONNREQ, EV_RECONNREQ, EV_RECONNREQ, EV_SHUTDOWN};
      default:         opt = '{EV_CONNREQ, EV_CONNREQ, EV_CONNREQ, EV_CONNREQ};
    endcase
    return opt[$urandom_range(0, 3)];
  endfunction

  // Random item shaped by the predicted state: mostly lifecycle-shaped
  // traffic, ticks while a timer runs, plus noise, soft resets and junk codes.
  function automatic void pick_item(output logic [FUNC_W-1:0] f, output logic [EVENT_W-1:0] e);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    e = EVENT_W'($urandom_range(0, 15));
    if (roll < 2) f = FUNC_UNUSED;
    else if (roll < 5) f = FUNC_SOFT;
    else if (roll < 15) f = FUNC_EVENT;
    else if ((sb.armed && roll < 60) || roll < 22) f = FUNC_TICK;
    else begin
      f = FUNC_EVENT;
      e = forward_event(sb.fsm);
    end
  endfunction

  initial begin : stimulus
    int unsigned ph;
    int unsigned useful;
    logic [FUNC_W-1:0]  f;
    logic [EVENT_W-1:0] e;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_EVENT;
    in_ch.event_code <= EV_NONE;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_AUTO_RECONNECT;
    cfg_wdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset-time registers first, with items that must change nothing.
    send_item(FUNC_TICK, EV_NONE);            // tick with no timer running
    idle_gap();
    send_item(FUNC_UNUSED, EV_UNKNOWN_HI);    // unused func code
    idle_gap();
    send_item(FUNC_EVENT, EV_UNKNOWN_LO);     // unknown event code
    wait_drain();

    // Tight limits so the timer paths show up within a few items.
    write_config(16'd1, 16'd1, 16'd2, 16'd0, 16'd3);
    send_item(FUNC_EVENT, EV_CONNREQ);
    send_item(FUNC_TICK, EV_NONE);
    send_item(FUNC_TICK, EV_NONE);            // connect timer expires at its limit
    idle_gap();
    send_item(FUNC_EVENT, EV_NETUP);
    send_item(FUNC_EVENT, EV_INITREQ);
    send_item(FUNC_TICK, EV_NONE);            // zero limit expires on the first tick
    send_item(FUNC_EVENT, EV_RECONNREQ);      // reconnect from error, uses the one attempt
    idle_gap();
    send_item(FUNC_EVENT, EV_NETUP);
    send_item(FUNC_EVENT, EV_INITSENT);
    send_item(FUNC_EVENT, EV_INITED);
    send_item(FUNC_EVENT, EV_NETDOWN);        // attempts exhausted: falls to disconnected
    send_item(FUNC_EVENT, EV_CONNREQ);
    send_item(FUNC_EVENT, EV_PROTERR);
    send_item(FUNC_EVENT, EV_RECONNREQ);      // refused, stays in error
    send_item(FUNC_EVENT, EV_TIMEOUT);        // timeout event has no effect in error
    idle_gap();
    send_item(FUNC_EVENT, EV_SHUTDOWN);
    send_item(FUNC_EVENT, EV_CONNREQ);        // leaving closed clears the count
    send_item(FUNC_EVENT, EV_TIMEOUT);        // external timeout: no timed_out flag
    send_item(FUNC_EVENT, EV_NETUP);
    send_item(FUNC_EVENT, EV_INITREQ);
    send_item(FUNC_EVENT, EV_INITRECV);
    send_item(FUNC_EVENT, EV_SHUTDOWN);
    send_item(FUNC_EVENT, EV_UNKNOWN_HI);     // unknown code while draining
    send_item(FUNC_SOFT, EV_UNKNOWN_HI);      // soft reset out of draining

    // Random phases, each under its own register setting.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      rx_steady = (ph == 4);
      tx_steady = (ph == 4);
      case (ph)
        0: write_config(16'd1, 16'd3, 16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                        16'($urandom_range(0, 8)));
        1: write_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);      // extremes
        2: write_config(16'd1, 16'd255, 16'($urandom_range(1, 10)), 16'hFFFF,
                        16'($urandom_range(1, 10)));
        3: write_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
        4: write_config(16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
        default: write_config(16'd1, 16'($urandom_range(1, 4)), 16'($urandom_range(0, 12)),
                              16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
      endcase

      // Last phase opens with a long receiver hold while items keep coming.
      if (ph == PHASES - 1) begin
        rx_hold_req = 1'b1;
        repeat (16) begin
          pick_item(f, e);
          send_item(f, e);
        end
      end

      useful = 0;
      while (useful < PHASE_ITEMS) begin
        pick_item(f, e);
        send_item(f, e);
        if (f != FUNC_UNUSED) useful++;
        if ((ph == 2 && useful == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
          wait_drain();
        else
          idle_gap();
      end
    end

    wait_drain();
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("run covered %0d items under %0d register settings:", items_sent, settings);
    $display("  %0d state changes, %0d timer expiries, %0d result items checked",
             sb.transitions, sb.expiries, sb.reports_checked);
    $display("%0d field mismatches, %0d still outstanding", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/slf_pkg.sv
rtl/slf_in_if.sv
rtl/slf_out_if.sv
rtl/slf_cfg.sv
rtl/slf_fsm.sv
rtl/session_lifecycle_fsm_core.sv
bench/session_lifecycle_fsm_core_tb.sv
